### rtl/cea608_pkg.sv
// Shared types, constants and helper functions for the CEA-608 caption line encoder.
package cea608_pkg;

   localparam int MAX_LINE_CHARS_DEF = 32;
   localparam int MAX_PAIRS          = 4;
   localparam int PAIR_IDX_W         = $clog2(MAX_PAIRS);
   localparam int PAIR_CNT_W         = $clog2(MAX_PAIRS + 1);
   localparam int FIFO_DEPTH         = 4;

   localparam logic [1:0] CSR_PAC_ROW       = 2'd0;
   localparam logic [1:0] CSR_PAC_UNDERLINE = 2'd1;
   localparam logic [1:0] CSR_PAC_ATTRIBUTE = 2'd2;

   localparam logic [3:0] PAC_ROW_RESET = 4'd15;

   localparam logic [7:0] CC_HEADER  = 8'hFC;
   localparam logic [6:0] CTRL_CHAN1 = 7'h14;
   localparam logic [6:0] CMD_RCL    = 7'h20;
   localparam logic [6:0] CMD_RU2    = 7'h25;
   localparam logic [6:0] CMD_CR     = 7'h2D;
   localparam logic [6:0] CMD_EOC    = 7'h2F;
   localparam logic [6:0] CHAR_SPACE = 7'h20;
   localparam logic [6:0] PAC_HI_BASE = 7'h10;
   localparam logic [6:0] PAC_LO_BASE = 7'h40;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [7:0] triplet_header;
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [6:0] first;
      logic [6:0] second;
   } pair_type;

   typedef struct packed {
      logic [PAIR_CNT_W-1:0]          count;
      pair_type [MAX_PAIRS-1:0]       pairs;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } queue_head_type;

   // Row code position for display rows 1..15.
   function automatic logic [3:0] row_index(input logic [3:0] row);
      logic [3:0] idx;
      case (row)
         4'd1:    idx = 4'd2;
         4'd2:    idx = 4'd3;
         4'd3:    idx = 4'd4;
         4'd4:    idx = 4'd5;
         4'd5:    idx = 4'd10;
         4'd6:    idx = 4'd11;
         4'd7:    idx = 4'd12;
         4'd8:    idx = 4'd13;
         4'd9:    idx = 4'd14;
         4'd10:   idx = 4'd15;
         4'd11:   idx = 4'd0;
         4'd12:   idx = 4'd6;
         4'd13:   idx = 4'd7;
         4'd14:   idx = 4'd8;
         4'd15:   idx = 4'd9;
         default: idx = 4'd0;
      endcase
      return idx;
   endfunction

   function automatic logic [7:0] odd_parity(input logic [6:0] v);
      return {~^v, v};
   endfunction

endpackage

### rtl/cea608_caption_line_encoder.sv
// Top level of the CEA-608 caption line encoder: front end, job queue, triplet back end.
// Flow: a request's job is written into the queue when the request is accepted, and the back end
//   registers each triplet that it offers; later triplets follow per cycle while rsp_stall is low.
// Throughput: one request per cycle into a 4-job queue while the queue is not full; the back end
//   sends one triplet per cycle while rsp_stall is low, and a request yields up to 4 triplets.
// Reset: synchronous, active high; clears line state, queue and output valid, PAC row to 15.
module cea608_caption_line_encoder #(
   parameter int MAX_LINE_CHARS = cea608_pkg::MAX_LINE_CHARS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  cea608_pkg::req_type  req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output cea608_pkg::rsp_type  rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [3:0]           csr_data
);
   import cea608_pkg::*;

   logic           queue_full;
   logic           queue_push;
   logic           queue_pop;
   job_type        queue_job;
   queue_head_type queue_head;

   cea608_front #(
      .MAX_LINE_CHARS(MAX_LINE_CHARS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .queue_full (queue_full),
      .queue_push (queue_push),
      .queue_job  (queue_job)
   );

   cea608_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (queue_push),
      .push_job (queue_job),
      .full     (queue_full),
      .pop      (queue_pop),
      .head     (queue_head)
   );

   cea608_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (queue_head),
      .pop       (queue_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/cea608_front.sv
// Front end: config registers, request accept, line state and command pair building.
module cea608_front #(
   parameter int MAX_LINE_CHARS = cea608_pkg::MAX_LINE_CHARS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  cea608_pkg::req_type  req_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [3:0]           csr_data,
   input  logic                 queue_full,
   output logic                 queue_push,
   output cea608_pkg::job_type  queue_job
);
   import cea608_pkg::*;

   localparam int CW = $clog2(MAX_LINE_CHARS + 1);

   logic [3:0]    pac_row_ff;
   logic          pac_underline_ff;
   logic [3:0]    pac_attribute_ff;

   logic [CW-1:0] count_ff, count_in;
   logic          started_ff, started_in;
   logic [1:0]    mode_ff, mode_in;
   logic [6:0]    held_ff, held_in;
   logic          held_valid_ff, held_valid_in;

   logic          req_fire;
   logic [6:0]    ch;
   logic [3:0]    idx;
   pair_type      pac_pair;
   job_type       job;

   assign csr_ready = 1'b1;
   assign req_stall = queue_full;
   assign req_fire  = req_valid && !req_stall;
   assign ch        = req_data.char_code[6:0];

   assign idx             = row_index(pac_row_ff);
   assign pac_pair.first  = PAC_HI_BASE | {4'd0, idx[3:1]};
   assign pac_pair.second = PAC_LO_BASE | {1'b0, idx[0], 5'd0}
                          | {2'd0, pac_attribute_ff, 1'b0} | {6'd0, pac_underline_ff};

   always_comb begin
      job           = '0;
      count_in      = count_ff;
      started_in    = started_ff;
      mode_in       = mode_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;

      if (count_ff == '0) begin
         mode_in       = req_data.func;
         held_valid_in = 1'b0;
         if (req_data.func[1]) begin
            job.pairs[job.count[PAIR_IDX_W-1:0]] = '{CTRL_CHAN1, CMD_RCL};
            job.count = job.count + 1'b1;
            if (pac_row_ff != 4'd0) begin
               job.pairs[job.count[PAIR_IDX_W-1:0]] = pac_pair;
               job.count = job.count + 1'b1;
            end
         end else if (req_data.func == 2'd0) begin
            job.pairs[job.count[PAIR_IDX_W-1:0]] = '{CTRL_CHAN1, CMD_RU2};
            job.count = job.count + 1'b1;
            if (started_ff) begin
               job.pairs[job.count[PAIR_IDX_W-1:0]] = '{CTRL_CHAN1, CMD_CR};
               job.count = job.count + 1'b1;
            end
            if (pac_row_ff != 4'd0) begin
               job.pairs[job.count[PAIR_IDX_W-1:0]] = pac_pair;
               job.count = job.count + 1'b1;
            end
            started_in = 1'b1;
         end else begin
            if (!started_ff) begin
               job.pairs[job.count[PAIR_IDX_W-1:0]] = '{CTRL_CHAN1, CMD_RU2};
               job.count = job.count + 1'b1;
            end
            if (pac_row_ff != 4'd0) begin
               job.pairs[job.count[PAIR_IDX_W-1:0]] = pac_pair;
               job.count = job.count + 1'b1;
            end
            started_in = 1'b1;
         end
      end

      if (count_ff < CW'(MAX_LINE_CHARS)) begin
         if (held_valid_in) begin
            job.pairs[job.count[PAIR_IDX_W-1:0]] = '{held_ff, ch};
            job.count     = job.count + 1'b1;
            held_valid_in = 1'b0;
         end else begin
            held_in       = ch;
            held_valid_in = 1'b1;
         end
         count_in = count_ff + 1'b1;
      end

      if (req_data.last_char) begin
         if (held_valid_in) begin
            job.pairs[job.count[PAIR_IDX_W-1:0]] = '{held_in, CHAR_SPACE};
            job.count     = job.count + 1'b1;
            held_valid_in = 1'b0;
         end
         if (mode_in[1]) begin
            job.pairs[job.count[PAIR_IDX_W-1:0]] = '{CTRL_CHAN1, CMD_EOC};
            job.count = job.count + 1'b1;
         end
         count_in = '0;
      end
   end

   assign queue_job  = job;
   assign queue_push = req_fire && (job.count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         pac_row_ff       <= PAC_ROW_RESET;
         pac_underline_ff <= 1'b0;
         pac_attribute_ff <= 4'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PAC_ROW:       pac_row_ff       <= csr_data;
            CSR_PAC_UNDERLINE: pac_underline_ff <= csr_data[0];
            CSR_PAC_ATTRIBUTE: pac_attribute_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         started_ff    <= 1'b0;
         mode_ff       <= 2'd0;
         held_valid_ff <= 1'b0;
      end else if (req_fire) begin
         count_ff      <= count_in;
         started_ff    <= started_in;
         mode_ff       <= mode_in;
         held_valid_ff <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         held_ff <= held_in;
      end
   end

endmodule

### rtl/cea608_fifo.sv
// Short job queue between the front end and the triplet back end.
module cea608_fifo (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  cea608_pkg::job_type         push_job,
   output logic                        full,
   input  logic                        pop,
   output cea608_pkg::queue_head_type  head
);
   import cea608_pkg::*;

   localparam int PW = $clog2(FIFO_DEPTH);
   localparam int CW = $clog2(FIFO_DEPTH + 1);

   job_type       mem_ff [FIFO_DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff, count_in;
   logic          do_pop;

   assign full       = (count_ff == CW'(FIFO_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.job   = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### rtl/cea608_back.sv
// Back end: walks queued jobs one pair per cycle, while the output is not stalled, into parity-coded output triplets.
module cea608_back (
   input  logic                        clock,
   input  logic                        reset,
   input  cea608_pkg::queue_head_type  head,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output cea608_pkg::rsp_type         rsp_data
);
   import cea608_pkg::*;

   logic [PAIR_IDX_W-1:0] idx_ff, idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  load;
   logic                  final_pair;
   pair_type              cur;

   assign load       = !rsp_valid_ff || !rsp_stall;
   assign cur        = head.job.pairs[idx_ff];
   assign final_pair = ({1'b0, idx_ff} + 1'b1) == head.job.count;
   assign pop        = load && head.valid && final_pair;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (load) begin
         rsp_valid_in = head.valid;
         if (head.valid) begin
            rsp_in.triplet_header = CC_HEADER;
            rsp_in.first_byte     = odd_parity(cur.first);
            rsp_in.second_byte    = odd_parity(cur.second);
            rsp_in.last_of_run    = final_pair;
            idx_in                = final_pair ? '0 : idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
